FILE: hdl/tiny_register_vm_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tiny register machine core.
// Each macro expands to one labeled concurrent assertion.
// ----------------------------------------------------------------------------
`ifndef TINY_REGISTER_VM_CORE_MACROS_SVH
`define TINY_REGISTER_VM_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TVM_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvm assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TVM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvm assertion failed");

`endif

FILE: hdl/tvm_pkg.sv
// ----------------------------------------------------------------------------
// tvm_pkg
// Shared widths, codes and control structs of the tiny register machine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tvm_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ADDR_W    = 12;
  localparam int unsigned REG_NUM_W = 4;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned OPCODE_W  = 2;

  localparam int unsigned MEMORY_WORDS_DEF     = 4096;
  localparam int unsigned DATA_STACK_DEPTH_DEF = 16;
  localparam int unsigned CALL_STACK_DEPTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_MEM_WRITE = 2'd0,
    OP_EXECUTE   = 2'd1,
    OP_MEM_READ  = 2'd2,
    OP_REG_READ  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_NOP  = 4'd0,
    CMD_LOAD = 4'd1,
    CMD_MOV  = 4'd2,
    CMD_ADD  = 4'd3,
    CMD_SUB  = 4'd4,
    CMD_MUL  = 4'd5,
    CMD_DIV  = 4'd6,
    CMD_PUSH = 4'd7,
    CMD_POP  = 4'd8,
    CMD_JMP  = 4'd9,
    CMD_JIZ  = 4'd10,
    CMD_JIH  = 4'd11,
    CMD_JSR  = 4'd12,
    CMD_RTS  = 4'd13
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_END       = 3'd1,
    ST_BAD_OP    = 3'd2,
    ST_DIV_ZERO  = 3'd3,
    ST_POP_EMPTY = 3'd4,
    ST_DATA_OVF  = 3'd5,
    ST_CALL_OVF  = 3'd6,
    ST_HALTED    = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FETCH,
    S_OPER,
    S_MOV_RD,
    S_DIV,
    S_POP,
    S_RET,
    S_DONE
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stk_flags_t;

  typedef struct packed {
    logic                 en;
    logic [REG_NUM_W-1:0] addr;
    logic [WORD_W-1:0]    data;
  } reg_wr_t;

endpackage

`default_nettype wire

FILE: hdl/tvm_req_if.sv
// ----------------------------------------------------------------------------
// tvm_req_if
// Request channel: one transaction per memory or register access or instruction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tvm_req_if;
  logic                           valid;
  logic                           ready;
  logic [tvm_pkg::OPCODE_W-1:0]   opcode;
  logic [tvm_pkg::ADDR_W-1:0]     address;
  logic [tvm_pkg::WORD_W-1:0]     write_data;

  modport source (output valid, opcode, address, write_data, input ready);
  modport sink   (input valid, opcode, address, write_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tvm_rsp_if.sv
// ----------------------------------------------------------------------------
// tvm_rsp_if
// Response channel: one transaction per accepted request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tvm_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [tvm_pkg::ADDR_W-1:0]     program_counter;
  logic [tvm_pkg::ADDR_W-1:0]     executed_address;
  logic                           halted;
  logic [tvm_pkg::STATUS_W-1:0]   status;
  logic [tvm_pkg::WORD_W-1:0]     read_data;

  modport source (output valid, program_counter, executed_address, halted, status,
                  read_data, input ready);
  modport sink   (input valid, program_counter, executed_address, halted, status,
                  read_data, output ready);
endinterface

`default_nettype wire

FILE: hdl/tvm_mem.sv
// ----------------------------------------------------------------------------
// tvm_mem
// Main word memory, one read and one write port, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvm_mem #(
  parameter int unsigned WORDS = tvm_pkg::MEMORY_WORDS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(WORDS)-1:0]      rd_addr,
  output logic      [tvm_pkg::WORD_W-1:0]    rd_data,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(WORDS)-1:0]      wr_addr,
  input  wire logic [tvm_pkg::WORD_W-1:0]    wr_data,
  output logic                               busy
);
  import tvm_pkg::*;

  localparam int unsigned AW = $clog2(WORDS);

  logic [WORD_W-1:0] mem [WORDS];
  logic [AW-1:0]     clr_addr;

  // The sweep writes zero to one word per cycle until the last word is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tvm_regs.sv
// ----------------------------------------------------------------------------
// tvm_regs
// Register file memory, two registered read ports and one write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvm_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [tvm_pkg::REG_NUM_W-1:0]   ra_addr,
  input  wire logic [tvm_pkg::REG_NUM_W-1:0]   rb_addr,
  output logic      [tvm_pkg::WORD_W-1:0]      ra_data,
  output logic      [tvm_pkg::WORD_W-1:0]      rb_data,
  input  wire tvm_pkg::reg_wr_t                wr
);
  import tvm_pkg::*;

  localparam int unsigned REGS = 2 ** REG_NUM_W;

  logic [WORD_W-1:0] mem [REGS];
  logic [REGS-1:0]   written;
  logic [WORD_W-1:0] ra_q, rb_q;
  logic              ra_ok, rb_ok;

  // A register never written reads as zero; the valid bits stand for reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    ra_q  <= mem[ra_addr];
    rb_q  <= mem[rb_addr];
    ra_ok <= written[ra_addr];
    rb_ok <= written[rb_addr];
  end

  assign ra_data = ra_ok ? ra_q : '0;
  assign rb_data = rb_ok ? rb_q : '0;

endmodule

`default_nettype wire

FILE: hdl/tvm_stack.sv
// ----------------------------------------------------------------------------
// tvm_stack
// LIFO stack in a small memory with a fill count; pop data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvm_stack #(
  parameter int unsigned WIDTH = tvm_pkg::WORD_W,
  parameter int unsigned DEPTH = tvm_pkg::DATA_STACK_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tvm_pkg::stk_req_t   req,
  input  wire logic [WIDTH-1:0]    push_data,
  output logic      [WIDTH-1:0]    pop_data,
  output tvm_pkg::stk_flags_t      flags
);
  import tvm_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [CW-1:0]    count;
  logic [CW-1:0]    top_idx;

  assign top_idx     = count - CW'(1);
  assign flags.full  = (count == CW'(DEPTH));
  assign flags.empty = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (req.push) begin
      count <= count + CW'(1);
    end else if (req.pop) begin
      count <= top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[count[IW-1:0]] <= push_data;
    end
    if (req.pop) begin
      pop_data <= mem[top_idx[IW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tvm_div.sv
// ----------------------------------------------------------------------------
// tvm_div
// Signed 16-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tvm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [tvm_pkg::WORD_W-1:0]    dividend,
  input  wire logic [tvm_pkg::WORD_W-1:0]    divisor,
  output logic                               done,
  output logic      [tvm_pkg::WORD_W-1:0]    quotient
);
  import tvm_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  logic               active;
  logic [CNT_W-1:0]   cnt;
  logic [WORD_W-1:0]  rem, quo, dvs;
  logic               neg;
  logic [WORD_W:0]    rem_sh;
  logic [WORD_W+1:0]  diff;

  assign rem_sh   = {rem, quo[WORD_W-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign quotient = neg ? (WORD_W)'(-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CNT_W'(WORD_W);
      end else if (active) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // Magnitudes are unsigned; the most negative value stays 0x8000 and works.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[WORD_W-1] ? (WORD_W)'(-dividend) : dividend;
      dvs <= divisor[WORD_W-1]  ? (WORD_W)'(-divisor)  : divisor;
      rem <= '0;
      neg <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
    end else if (active) begin
      if (!diff[WORD_W+1]) begin
        rem <= diff[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tiny_register_vm_core.sv
// ----------------------------------------------------------------------------
// tiny_register_vm_core
// A 16-bit register machine built around a main word memory, a register
// file memory and two stack memories, driven by a sequencer.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Transaction carries
//  --------+-----------+-------------------------------------------------------
//  req     | in        | opcode, address, write_data
//  rsp     | out       | program_counter, executed_address, halted, status,
//          |           | read_data
//
// Sequence: a memory write goes from acceptance straight to the response,
// a memory or register read adds a read step, and most instructions pass
// through fetch, operand read, execute and response. MOV from memory, POP
// and RTS add a step for the extra memory or stack read; DIV waits for
// the bit-serial divider. Reset: synchronous and active high. After reset
// the main memory is swept to zero, one word per cycle; no request is
// taken during the sweep.
// Stalls: a finished response sits in the output register while the next
// request is accepted; the sequencer only waits if a second response is
// ready before the first one has been taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tiny_register_vm_core #(
  parameter int unsigned MEMORY_WORDS     = tvm_pkg::MEMORY_WORDS_DEF,
  parameter int unsigned DATA_STACK_DEPTH = tvm_pkg::DATA_STACK_DEPTH_DEF,
  parameter int unsigned CALL_STACK_DEPTH = tvm_pkg::CALL_STACK_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  tvm_req_if.sink   req,
  tvm_rsp_if.source rsp
);
  import tvm_pkg::*;

  localparam int unsigned AW = $clog2(MEMORY_WORDS);
  // Reciprocal for the address fold; exact for every 12-bit address.
  localparam int unsigned RECIP = ((1 << 24) + MEMORY_WORDS - 1) / MEMORY_WORDS;

  // Folds a 12-bit address onto the memory. The quotient is at most 15, so
  // one multiply by the reciprocal and one subtract give the remainder.
  function automatic logic [AW-1:0] mem_index(input logic [ADDR_W-1:0] a);
    logic [29:0] prod;
    logic [4:0]  q;
    logic [12:0] rem;
    prod = 30'(a) * 30'(RECIP);
    q    = prod[28:24];
    rem  = 13'(a) - 13'(32'(q) * MEMORY_WORDS);
    return rem[AW-1:0];
  endfunction

  // Sequencer state.
  state_t             state, state_next;
  op_t                op_l, op_next;
  logic [WORD_W-1:0]  instr, instr_next;
  logic [ADDR_W-1:0]  pc, pc_next;
  logic               stopped, stopped_next;
  status_t            res_status, status_next;
  logic [ADDR_W-1:0]  res_exec, exec_next;
  logic [WORD_W-1:0]  res_rd, rd_next;

  // Output register.
  logic               out_valid;
  logic [ADDR_W-1:0]  out_pc, out_exec;
  logic               out_halted;
  status_t            out_status;
  logic [WORD_W-1:0]  out_rd;
  logic               out_load;

  // Memory ports.
  logic               mem_rd_en, mem_wr_en, mem_busy;
  logic [AW-1:0]      mem_rd_addr, mem_wr_addr;
  logic [WORD_W-1:0]  mem_rd_data, mem_wr_data;

  // Register file ports.
  logic [REG_NUM_W-1:0] ra_addr, rb_addr;
  logic [WORD_W-1:0]    ra_data, rb_data;
  reg_wr_t              rwr;

  // Stacks.
  stk_req_t           dreq, creq;
  stk_flags_t         dflags, cflags;
  logic [WORD_W-1:0]  dpop_data;
  logic [ADDR_W-1:0]  cpop_data, cpush_data;

  // Divider.
  logic               div_start, div_done;
  logic [WORD_W-1:0]  div_q;

  // Decoded instruction fields.
  cmd_t                 cmd, fetch_cmd;
  logic [REG_NUM_W-1:0] rx, ry;
  logic                 from_mem, to_mem;
  logic [ADDR_W-1:0]    imm, pc_inc;
  logic [WORD_W-1:0]    mov_val;

  assign cmd        = cmd_t'(instr[3:0]);
  assign fetch_cmd  = cmd_t'(mem_rd_data[3:0]);
  assign rx         = instr[7:4];
  assign ry         = instr[11:8];
  assign from_mem   = instr[12];
  assign to_mem     = instr[13];
  assign imm        = instr[15:4];
  assign pc_inc     = pc + ADDR_W'(1);
  assign cpush_data = pc_inc;
  assign mov_val    = (state == S_MOV_RD) ? mem_rd_data : rb_data;

  assign req.ready = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  tvm_mem #(.WORDS(MEMORY_WORDS)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .busy    (mem_busy)
  );

  tvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .ra_data (ra_data),
    .rb_data (rb_data),
    .wr      (rwr)
  );

  tvm_stack #(.WIDTH(WORD_W), .DEPTH(DATA_STACK_DEPTH)) u_dstack (
    .clk       (clk),
    .rst       (rst),
    .req       (dreq),
    .push_data (ra_data),
    .pop_data  (dpop_data),
    .flags     (dflags)
  );

  tvm_stack #(.WIDTH(ADDR_W), .DEPTH(CALL_STACK_DEPTH)) u_cstack (
    .clk       (clk),
    .rst       (rst),
    .req       (creq),
    .push_data (cpush_data),
    .pop_data  (cpop_data),
    .flags     (cflags)
  );

  tvm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (ra_data),
    .divisor  (rb_data),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      pc         <= '0;
      stopped    <= 1'b0;
      op_l       <= OP_MEM_WRITE;
      res_status <= ST_OK;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      stopped    <= stopped_next;
      op_l       <= op_next;
      res_status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    instr    <= instr_next;
    res_exec <= exec_next;
    res_rd   <= rd_next;
  end

  // Output register: loads when a response is finished and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pc     <= pc;
      out_exec   <= res_exec;
      out_halted <= stopped;
      out_status <= res_status;
      out_rd     <= res_rd;
    end
  end

  assign rsp.valid            = out_valid;
  assign rsp.program_counter  = out_pc;
  assign rsp.executed_address = out_exec;
  assign rsp.halted           = out_halted;
  assign rsp.status           = out_status;
  assign rsp.read_data        = out_rd;

  always_comb begin
    state_next   = state;
    pc_next      = pc;
    stopped_next = stopped;
    op_next      = op_l;
    status_next  = res_status;
    instr_next   = instr;
    exec_next    = res_exec;
    rd_next      = res_rd;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = '0;
    mem_wr_data  = '0;
    ra_addr      = '0;
    rb_addr      = '0;
    rwr          = '0;
    dreq         = '0;
    creq         = '0;
    div_start    = 1'b0;

    unique case (state)
      S_CLEAR: begin
        if (!mem_busy) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req.valid) begin
          op_next     = op_t'(req.opcode);
          status_next = ST_OK;
          exec_next   = '0;
          rd_next     = '0;
          unique case (op_t'(req.opcode))
            OP_MEM_WRITE: begin
              mem_wr_en   = 1'b1;
              mem_wr_addr = mem_index(req.address);
              mem_wr_data = req.write_data;
              state_next  = S_DONE;
            end
            OP_MEM_READ: begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = mem_index(req.address);
              state_next  = S_READ;
            end
            OP_REG_READ: begin
              ra_addr    = req.address[REG_NUM_W-1:0];
              state_next = S_READ;
            end
            OP_EXECUTE: begin
              if (stopped) begin
                status_next = ST_HALTED;
                state_next  = S_DONE;
              end else begin
                exec_next   = pc;
                mem_rd_en   = 1'b1;
                mem_rd_addr = mem_index(pc);
                state_next  = S_FETCH;
              end
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      S_READ: begin
        rd_next    = (op_l == OP_MEM_READ) ? mem_rd_data : ra_data;
        state_next = S_DONE;
      end

      S_FETCH: begin
        // The conditional jumps test register 0 through port a.
        instr_next = mem_rd_data;
        ra_addr    = (fetch_cmd == CMD_JIZ || fetch_cmd == CMD_JIH) ? '0
                                                                    : mem_rd_data[7:4];
        rb_addr    = mem_rd_data[11:8];
        state_next = S_OPER;
      end

      S_OPER: begin
        // Keep the operand registers addressed so that the memory-sourced MOV
        // still sees the destination pointer in the following cycle.
        ra_addr    = rx;
        rb_addr    = ry;
        state_next = S_DONE;
        unique case (cmd)
          CMD_NOP: pc_next = pc_inc;
          CMD_LOAD: begin
            rwr.en   = 1'b1;
            rwr.addr = '0;
            rwr.data = {{(WORD_W-ADDR_W){1'b0}}, imm};
            pc_next  = pc_inc;
          end
          CMD_MOV: begin
            if (from_mem) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = mem_index(rb_data[ADDR_W-1:0]);
              state_next  = S_MOV_RD;
            end else begin
              if (to_mem) begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = mem_index(ra_data[ADDR_W-1:0]);
                mem_wr_data = mov_val;
              end else begin
                rwr.en   = 1'b1;
                rwr.addr = rx;
                rwr.data = mov_val;
              end
              pc_next = pc_inc;
            end
          end
          CMD_ADD: begin
            rwr.en   = 1'b1;
            rwr.addr = rx;
            rwr.data = ra_data + rb_data;
            pc_next  = pc_inc;
          end
          CMD_SUB: begin
            rwr.en   = 1'b1;
            rwr.addr = rx;
            rwr.data = ra_data - rb_data;
            pc_next  = pc_inc;
          end
          CMD_MUL: begin
            rwr.en   = 1'b1;
            rwr.addr = rx;
            rwr.data = WORD_W'(ra_data * rb_data);
            pc_next  = pc_inc;
          end
          CMD_DIV: begin
            if (rb_data == '0) begin
              stopped_next = 1'b1;
              status_next  = ST_DIV_ZERO;
            end else begin
              div_start  = 1'b1;
              state_next = S_DIV;
            end
          end
          CMD_PUSH: begin
            if (dflags.full) begin
              stopped_next = 1'b1;
              status_next  = ST_DATA_OVF;
            end else begin
              dreq.push = 1'b1;
              pc_next   = pc_inc;
            end
          end
          CMD_POP: begin
            if (dflags.empty) begin
              stopped_next = 1'b1;
              status_next  = ST_POP_EMPTY;
            end else begin
              dreq.pop   = 1'b1;
              state_next = S_POP;
            end
          end
          CMD_JMP: pc_next = imm;
          CMD_JIZ: pc_next = (ra_data == '0) ? imm : pc_inc;
          CMD_JIH: pc_next = (ra_data != '0 && !ra_data[WORD_W-1]) ? imm : pc_inc;
          CMD_JSR: begin
            if (cflags.full) begin
              stopped_next = 1'b1;
              status_next  = ST_CALL_OVF;
            end else begin
              creq.push = 1'b1;
              pc_next   = imm;
            end
          end
          CMD_RTS: begin
            // Returning with no caller ends the program.
            if (cflags.empty) begin
              stopped_next = 1'b1;
              status_next  = ST_END;
              pc_next      = pc_inc;
            end else begin
              creq.pop   = 1'b1;
              state_next = S_RET;
            end
          end
          default: begin
            stopped_next = 1'b1;
            status_next  = ST_BAD_OP;
          end
        endcase
      end

      S_MOV_RD: begin
        if (to_mem) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = mem_index(ra_data[ADDR_W-1:0]);
          mem_wr_data = mov_val;
        end else begin
          rwr.en   = 1'b1;
          rwr.addr = rx;
          rwr.data = mov_val;
        end
        pc_next    = pc_inc;
        state_next = S_DONE;
      end

      S_DIV: begin
        if (div_done) begin
          rwr.en     = 1'b1;
          rwr.addr   = rx;
          rwr.data   = div_q;
          pc_next    = pc_inc;
          state_next = S_DONE;
        end
      end

      S_POP: begin
        rwr.en     = 1'b1;
        rwr.addr   = rx;
        rwr.data   = dpop_data;
        pc_next    = pc_inc;
        state_next = S_DONE;
      end

      S_RET: begin
        pc_next    = cpop_data;
        state_next = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/tvm_chk.sv
// ----------------------------------------------------------------------------
// tvm_chk
// Port-level checks of the response channel, bound to the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tiny_register_vm_core_macros.svh"

module tvm_chk (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          rsp_valid,
  input wire logic                          rsp_ready,
  input wire logic [tvm_pkg::ADDR_W-1:0]    program_counter,
  input wire logic [tvm_pkg::ADDR_W-1:0]    executed_address,
  input wire logic                          halted,
  input wire logic [tvm_pkg::STATUS_W-1:0]  status,
  input wire logic [tvm_pkg::WORD_W-1:0]    read_data
);
  import tvm_pkg::*;

  // A response that is not taken keeps its contents.
  `TVM_ASSERT_NEXT(a_rsp_hold, clk, rst, (rsp_valid && !rsp_ready), (rsp_valid && $stable(program_counter) && $stable(status) && $stable(read_data) && $stable(halted)))

  // Every fault, and the end of the program, leaves the machine halted.
  `TVM_ASSERT_IMPLY(a_fault_halts, clk, rst, (rsp_valid && (status == ST_BAD_OP || status == ST_DIV_ZERO || status == ST_POP_EMPTY || status == ST_DATA_OVF || status == ST_CALL_OVF || status == ST_END)), (halted))

  // A step refused while halted executes nothing.
  `TVM_ASSERT_IMPLY(a_halted_no_exec, clk, rst, (rsp_valid && status == ST_HALTED), (halted && executed_address == '0))

  // While running, every response reports success.
  `TVM_ASSERT_IMPLY(a_running_ok, clk, rst, (rsp_valid && !halted), (status == ST_OK))

endmodule

bind tiny_register_vm_core tvm_chk u_tvm_chk (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .program_counter  (rsp.program_counter),
  .executed_address (rsp.executed_address),
  .halted           (rsp.halted),
  .status           (rsp.status),
  .read_data        (rsp.read_data)
);

`default_nettype wire

FILE: dv/tb_tiny_register_vm_core.sv
// ----------------------------------------------------------------------------
// tb_tiny_register_vm_core
// Self-checking bench for the tiny register machine core. Small programs are
// written into main memory one instruction at a time and then stepped. A
// behavioral copy of the machine predicts every response, and a monitor
// compares each response field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_tiny_register_vm_core;
  import tvm_pkg::*;

  // Command codes 14 and 15 are not part of the instruction set.
  localparam logic [3:0] CMD_INVALID_A = 4'd14;
  localparam logic [3:0] CMD_INVALID_B = 4'd15;
  localparam int         STACK_DEPTH   = 16;
  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         DRAIN_CYCLES  = 40;

  typedef struct {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] data;
    bit                drain;  // marker: hold the request side until all responses are back
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] pc;
    logic [ADDR_W-1:0] exec_addr;
    logic              halted;
    status_t           status;
    logic [WORD_W-1:0] rdata;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tvm_req_if req_if ();
  tvm_rsp_if rsp_if ();

  tiny_register_vm_core i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // Behavioral machine state. It is advanced as each request is generated,
  // which matches acceptance order because requests are sent strictly in order.
  logic [WORD_W-1:0] vm_mem [4096];
  logic [WORD_W-1:0] vm_regs [16];
  logic [ADDR_W-1:0] vm_pc;
  logic [WORD_W-1:0] vm_dstack [STACK_DEPTH];
  int                vm_dcount;
  logic [ADDR_W-1:0] vm_cstack [STACK_DEPTH];
  int                vm_ccount;
  bit                vm_stopped;

  request_t  pending_q [$];
  response_t response_q [$];

  int n_accepted = 0;
  int n_received = 0;
  int n_errors   = 0;
  int n_executes = 0;
  int n_queued   = 0;
  int send_idle  = 17;
  int recv_idle  = 61;
  int cycles     = 0;
  int hold_left  = 0;
  bit hold_done  = 0;
  status_t final_fault = ST_OK;

  // Executes the instruction at the program counter and returns the status.
  function automatic status_t step_instruction();
    logic [WORD_W-1:0] w;
    logic [3:0]        rx, ry;
    logic [ADDR_W-1:0] imm, nxt;
    logic [WORD_W-1:0] v;
    int                sa, sb, q;
    w   = vm_mem[vm_pc];
    rx  = w[7:4];
    ry  = w[11:8];
    imm = w[15:4];
    nxt = vm_pc + 12'd1;
    case (w[3:0])
      CMD_NOP: ;
      CMD_LOAD: vm_regs[0] = {4'd0, imm};
      CMD_MOV: begin
        v = w[12] ? vm_mem[vm_regs[ry][11:0]] : vm_regs[ry];
        if (w[13]) vm_mem[vm_regs[rx][11:0]] = v;
        else vm_regs[rx] = v;
      end
      CMD_ADD: vm_regs[rx] = vm_regs[rx] + vm_regs[ry];
      CMD_SUB: vm_regs[rx] = vm_regs[rx] - vm_regs[ry];
      CMD_MUL: vm_regs[rx] = vm_regs[rx] * vm_regs[ry];
      CMD_DIV: begin
        if (vm_regs[ry] == '0) begin
          vm_stopped = 1;
          return ST_DIV_ZERO;
        end
        sa = $signed(vm_regs[rx]);
        sb = $signed(vm_regs[ry]);
        q  = sa / sb;
        vm_regs[rx] = q[15:0];
      end
      CMD_PUSH: begin
        if (vm_dcount >= STACK_DEPTH) begin
          vm_stopped = 1;
          return ST_DATA_OVF;
        end
        vm_dstack[vm_dcount] = vm_regs[rx];
        vm_dcount++;
      end
      CMD_POP: begin
        if (vm_dcount == 0) begin
          vm_stopped = 1;
          return ST_POP_EMPTY;
        end
        vm_dcount--;
        vm_regs[rx] = vm_dstack[vm_dcount];
      end
      CMD_JMP: begin
        vm_pc = imm;
        return ST_OK;
      end
      CMD_JIZ: begin
        vm_pc = (vm_regs[0] == '0) ? imm : nxt;
        return ST_OK;
      end
      CMD_JIH: begin
        vm_pc = (vm_regs[0] != '0 && !vm_regs[0][15]) ? imm : nxt;
        return ST_OK;
      end
      CMD_JSR: begin
        if (vm_ccount >= STACK_DEPTH) begin
          vm_stopped = 1;
          return ST_CALL_OVF;
        end
        vm_cstack[vm_ccount] = nxt;
        vm_ccount++;
        vm_pc = imm;
        return ST_OK;
      end
      CMD_RTS: begin
        if (vm_ccount == 0) begin
          vm_stopped = 1;
          vm_pc = nxt;
          return ST_END;
        end
        vm_ccount--;
        vm_pc = vm_cstack[vm_ccount];
        return ST_OK;
      end
      default: begin
        vm_stopped = 1;
        return ST_BAD_OP;
      end
    endcase
    vm_pc = nxt;
    return ST_OK;
  endfunction

  // Queues one request and the response the machine will give for it.
  function automatic void send_request(op_t op, logic [ADDR_W-1:0] addr,
                                       logic [WORD_W-1:0] data);
    request_t  r;
    response_t e;
    r = '{op: op, addr: addr, data: data, drain: 0};
    e = '{pc: '0, exec_addr: '0, halted: 0, status: ST_OK, rdata: '0};
    case (op)
      OP_MEM_WRITE: vm_mem[addr] = data;
      OP_EXECUTE: begin
        n_executes++;
        if (vm_stopped) begin
          e.status = ST_HALTED;
        end else begin
          e.exec_addr = vm_pc;
          e.status    = step_instruction();
        end
      end
      OP_MEM_READ: e.rdata = vm_mem[addr];
      default:     e.rdata = vm_regs[addr[3:0]];
    endcase
    e.pc     = vm_pc;
    e.halted = vm_stopped;
    pending_q.push_back(r);
    response_q.push_back(e);
    n_queued++;
  endfunction

  function automatic void request_drain();
    request_t r;
    r = '{op: OP_MEM_WRITE, addr: '0, data: '0, drain: 1};
    pending_q.push_back(r);
  endfunction

  // Places an instruction at the program counter and steps it.
  function automatic void run_word(logic [WORD_W-1:0] w);
    send_request(OP_MEM_WRITE, vm_pc, w);
    send_request(OP_EXECUTE, $urandom, $urandom);
  endfunction

  function automatic logic [WORD_W-1:0] reg_word(logic [3:0] cmd, logic [3:0] rx,
                                                 logic [3:0] ry, bit from_mem = 0,
                                                 bit to_mem = 0);
    return {2'($urandom), to_mem, from_mem, ry, rx, cmd};
  endfunction

  function automatic logic [WORD_W-1:0] jump_word(logic [3:0] cmd, logic [11:0] target);
    return {target, cmd};
  endfunction

  // Picks a random instruction that cannot halt the machine in its current state.
  function automatic logic [WORD_W-1:0] safe_word();
    logic [WORD_W-1:0] w;
    logic [3:0]        cmd;
    forever begin
      w   = $urandom;
      cmd = $urandom_range(CMD_NOP, CMD_RTS);
      w[3:0] = cmd;
      case (cmd)
        CMD_DIV:  if (vm_regs[w[11:8]] != '0) return w;
        CMD_PUSH: if (vm_dcount < STACK_DEPTH) return w;
        CMD_POP:  if (vm_dcount > 0) return w;
        CMD_JSR:  if (vm_ccount < STACK_DEPTH) return w;
        CMD_RTS:  if (vm_ccount > 0) return w;
        default:  return w;
      endcase
    end
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
      n_errors++;
    end
  endfunction

  // Request driver. A new transaction is offered only when the previous one
  // has been taken, so valid never drops while a transaction is waiting.
  always @(posedge clk) begin
    request_t r;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready) n_accepted <= n_accepted + 1;
      if (!req_if.valid || req_if.ready) begin
        if (pending_q.size() > 0 && pending_q[0].drain) begin
          // Pause until every response so far has come back.
          req_if.valid <= 1'b0;
          if (!req_if.valid && n_received == n_accepted) void'(pending_q.pop_front());
        end else if (pending_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          r = pending_q.pop_front();
          req_if.valid      <= 1'b1;
          req_if.opcode     <= r.op;
          req_if.address    <= r.addr;
          req_if.write_data <= r.data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready. One long hold-off fills the core while requests keep coming.
  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else if (!hold_done && n_accepted >= 120) begin
      hold_done    <= 1;
      hold_left    <= 400;
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Idle profile moves through its three phases as requests are accepted.
  always @(posedge clk) begin
    if (n_accepted >= 300) begin
      send_idle <= 0;
      recv_idle <= 0;
    end else if (n_accepted >= 150) begin
      send_idle <= 61;
      recv_idle <= 17;
    end
  end

  // Response monitor: every transaction is checked against the oldest prediction.
  always @(posedge clk) begin
    response_t e;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      n_received <= n_received + 1;
      if (response_q.size() == 0) begin
        $display("%0t: response with no request outstanding", $time);
        n_errors++;
      end else begin
        e = response_q.pop_front();
        check_field("program_counter", e.pc, rsp_if.program_counter);
        check_field("executed_address", e.exec_addr, rsp_if.executed_address);
        check_field("halted", e.halted, rsp_if.halted);
        check_field("status", e.status, rsp_if.status);
        check_field("read_data", e.rdata, rsp_if.read_data);
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int burst;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_MEM_WRITE;
    req_if.address    = '0;
    req_if.write_data = '0;
    rsp_if.ready      = 1'b0;

    foreach (vm_mem[i]) vm_mem[i] = '0;
    foreach (vm_regs[i]) vm_regs[i] = '0;
    vm_pc = '0;
    vm_dcount = 0;
    vm_ccount = 0;
    vm_stopped = 0;

    // Directed part: memory extremes, every command, signed divide corner.
    send_request(OP_MEM_WRITE, 12'hFFF, 16'hFFFF);
    send_request(OP_MEM_READ, 12'hFFF, '0);
    send_request(OP_MEM_READ, 12'h000, '0);
    send_request(OP_REG_READ, 12'hFFF, '0);
    run_word(reg_word(CMD_NOP, 0, 0));
    run_word(jump_word(CMD_LOAD, 12'd5));
    run_word(reg_word(CMD_MOV, 3, 0));
    send_request(OP_MEM_WRITE, 12'd5, 16'h8000);
    run_word(reg_word(CMD_MOV, 1, 3, 1));       // register from memory
    send_request(OP_MEM_WRITE, 12'd5, 16'hFFFF);
    run_word(reg_word(CMD_MOV, 2, 3, 1));
    run_word(reg_word(CMD_DIV, 1, 2));          // most negative by minus one wraps
    run_word(reg_word(CMD_MOV, 3, 1, 0, 1));    // memory from register
    run_word(reg_word(CMD_MOV, 3, 3, 1, 1));    // memory to memory
    run_word(reg_word(CMD_ADD, 1, 1));
    run_word(reg_word(CMD_SUB, 2, 3));
    run_word(reg_word(CMD_MUL, 2, 2));
    run_word(jump_word(CMD_JIZ, 12'h800));
    run_word(jump_word(CMD_JIH, 12'hFFF));
    run_word(reg_word(CMD_PUSH, 2, 0));
    run_word(jump_word(CMD_JSR, 12'h010));
    run_word(reg_word(CMD_POP, 7, 0));
    run_word(jump_word(CMD_RTS, 12'h000));
    run_word(jump_word(CMD_JMP, 12'h000));
    request_drain();

    // Random part: mostly well-formed instruction steps, with stack bursts and noise.
    while (n_queued < 440) begin
      case ($urandom_range(19))
        0: begin
          burst = $urandom_range(STACK_DEPTH);
          repeat (burst)
            if (vm_dcount < STACK_DEPTH) run_word(reg_word(CMD_PUSH, $urandom, 0));
        end
        1: begin
          while (vm_dcount > 0) run_word(reg_word(CMD_POP, $urandom, 0));
        end
        2: begin
          while (vm_ccount < STACK_DEPTH) run_word(jump_word(CMD_JSR, $urandom));
        end
        3: begin
          while (vm_ccount > 0) run_word(jump_word(CMD_RTS, 0));
        end
        4, 5, 6, 7: send_request(op_t'($urandom_range(OP_MEM_WRITE, OP_REG_READ)), $urandom,
                                 $urandom);
        8: request_drain();
        default: run_word(safe_word());
      endcase
    end

    // One fault or program end to close the program, chosen by the seed, then steps while halted.
    case ($urandom_range(5))
      0: begin
        run_word(jump_word(CMD_LOAD, 0));
        run_word(reg_word(CMD_DIV, $urandom, 0));
      end
      1: begin
        while (vm_dcount > 0) run_word(reg_word(CMD_POP, 1, 0));
        run_word(reg_word(CMD_POP, 1, 0));
      end
      2: begin
        while (vm_dcount <= STACK_DEPTH && !vm_stopped) run_word(reg_word(CMD_PUSH, 1, 0));
      end
      3: begin
        while (!vm_stopped) run_word(jump_word(CMD_JSR, $urandom));
      end
      4: run_word(reg_word($urandom_range(1) ? CMD_INVALID_A : CMD_INVALID_B, 0, 0));
      default: begin
        while (!vm_stopped) run_word(jump_word(CMD_RTS, 0));
      end
    endcase
    final_fault = response_q[$].status;
    repeat (3) send_request(OP_EXECUTE, $urandom, $urandom);
    for (int i = 0; i < 16; i++) send_request(OP_REG_READ, i, '0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_q.size() == 0 && response_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions, %0d instruction steps, closing fault status %0d",
             n_received, n_executes, final_fault);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("status: fail");
    end
    $finish;
  end

endmodule
